FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the shortest path block.
// Included by the modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Implication checked also during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: hw/rtl/spd_pkg.sv
// Package for the shortest path block: constants, payload structs, command codes.
// Used by spd_ctrl, spd_dp and shortest_path_dijkstra; depends on nothing.
`default_nettype none
package spd_pkg;
   localparam int MAX_NODES   = 64;
   localparam int MAX_EDGES   = 512;
   localparam int WEIGHT_BITS = 16;
   localparam int NODE_BITS   = $clog2(MAX_NODES);
   localparam int EDGE_BITS   = $clog2(MAX_EDGES);
   localparam int ETOT_BITS   = $clog2(MAX_EDGES + 1);
   localparam int NCNT_BITS   = $clog2(MAX_NODES + 1);
   localparam int COST_BITS   = 22;
   localparam logic [COST_BITS-1:0] COST_MAX = '1;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_RUN   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [5:0]  edge_source;
      logic [5:0]  edge_target;
      logic [15:0] edge_weight;
      logic [5:0]  start_node;
   } req_type;

   typedef struct packed {
      logic [5:0]  node_index;
      logic [21:0] path_cost;
      logic [5:0]  predecessor;
      logic        has_predecessor;
      logic        reached;
      logic        edges_dropped;
      logic        last;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic init;       // clear tables, seed start node
      logic scan_clr;   // begin minimum scan
      logic scan_step;  // examine node at scan index
      logic visit;      // mark best node visited, start edge sweep
      logic edge_rd;    // issue edge read at edge index
      logic edge_relax; // relax the edge in the delayed edge register
      logic emit_load;  // load result register from node index
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic scan_done;  // scan index passed last node, last compare done
      logic found;      // scan found an unvisited reached node
      logic edge_done;  // edge index reached edge total
      logic emit_done;  // emit index passed last node
   } sts_type;
endpackage
`default_nettype wire

FILE: hw/rtl/spd_dp.sv
// Datapath of the shortest path block: edge memory, node tables, scan and relax logic.
// Depends on spd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module spd_dp (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [6:0]                 node_count,
   input  wire logic                       load_we,
   input  wire logic                       clear_we,
   input  wire spd_pkg::req_type           req_word,
   input  wire spd_pkg::cmd_type           cmd,
   output      spd_pkg::sts_type           sts,
   output      spd_pkg::rsp_type           rsp_word
);
   localparam int NB = spd_pkg::NODE_BITS;
   localparam int CB = spd_pkg::COST_BITS;
   localparam int WB = spd_pkg::WEIGHT_BITS;
   localparam int EB = spd_pkg::EDGE_BITS;
   localparam int TB = spd_pkg::ETOT_BITS;
   localparam int KB = spd_pkg::NCNT_BITS;

   // Edge memory, one write port and one registered read port.
   logic [2*NB+WB-1:0] edge_mem [spd_pkg::MAX_EDGES];
   logic [2*NB+WB-1:0] edge_rd_ff;
   logic [2*NB+WB-1:0] edge_d_ff;
   logic [TB-1:0] etot_ff, etot_in;
   logic          ovf_ff, ovf_in;

   // Node tables, one registered read port shared by scan, relax and emit.
   logic [CB-1:0] dist_ff [spd_pkg::MAX_NODES];
   logic [NB-1:0] pred_ff [spd_pkg::MAX_NODES];
   logic [spd_pkg::MAX_NODES-1:0] pv_ff, reach_ff, vis_ff;
   logic [CB-1:0] dist_rd_ff;
   logic [NB-1:0] pred_rd_ff;
   logic [NB-1:0] rd_addr;

   logic [KB-1:0] n_eff;
   logic [KB-1:0] scan_ff, scan_in;
   logic          scan_issue;
   logic          step_d_ff;
   logic [NB-1:0] sidx_d_ff;
   logic          emit_d_ff;
   logic [NB-1:0] best_ff, best_in;
   logic          found_ff, found_in;
   logic [CB-1:0] bdist_ff, bdist_in;
   logic [TB-1:0] eidx_ff, eidx_in;
   logic [NB-1:0] start_ff;
   logic          fw_vld_ff;
   logic [NB-1:0] fw_addr_ff;
   logic [CB-1:0] fw_val_ff;
   spd_pkg::rsp_type rsp_ff;

   logic [NB-1:0] sidx;
   logic          cand_ok;
   logic [NB-1:0] e1_dst;
   logic [NB-1:0] e_src, e_dst;
   logic [WB-1:0] e_w;
   logic [CB:0]   sum;
   logic [CB-1:0] cand;
   logic [CB-1:0] dist_cur;
   logic          relax_hit;

   always_comb begin
      if (node_count == 7'd0) begin
         n_eff = KB'(1);
      end else if (node_count > 7'(spd_pkg::MAX_NODES)) begin
         n_eff = KB'(spd_pkg::MAX_NODES);
      end else begin
         n_eff = KB'(node_count);
      end
   end

   always_comb begin
      etot_in = etot_ff;
      ovf_in  = ovf_ff;
      if (clear_we) begin
         etot_in = '0;
         ovf_in  = 1'b0;
      end else if (load_we) begin
         if (etot_ff < TB'(spd_pkg::MAX_EDGES)) begin
            etot_in = etot_ff + TB'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_we && !clear_we && etot_ff < TB'(spd_pkg::MAX_EDGES)) begin
         edge_mem[etot_ff[EB-1:0]] <= {req_word.edge_source, req_word.edge_target,
                                       req_word.edge_weight[WB-1:0]};
      end
      if (cmd.edge_rd) begin
         edge_rd_ff <= edge_mem[eidx_ff[EB-1:0]];
      end
   end

   // Scan: one node issued per cycle, compared in the next cycle on the read data.
   // Strict less keeps the lowest index on ties.
   assign sidx       = scan_ff[NB-1:0];
   assign scan_issue = cmd.scan_step && scan_ff < n_eff;
   assign cand_ok    = step_d_ff && reach_ff[sidx_d_ff] && !vis_ff[sidx_d_ff];

   always_comb begin
      scan_in  = scan_ff;
      best_in  = best_ff;
      found_in = found_ff;
      bdist_in = bdist_ff;
      if (cmd.scan_clr || cmd.init) begin
         scan_in  = '0;
         found_in = 1'b0;
      end else begin
         if (scan_issue || cmd.emit_load) begin
            scan_in = scan_ff + KB'(1);
         end
         if (cand_ok && (!found_ff || dist_rd_ff < bdist_ff)) begin
            best_in  = sidx_d_ff;
            found_in = 1'b1;
            bdist_in = dist_rd_ff;
         end
      end
   end

   always_comb begin
      eidx_in = eidx_ff;
      if (cmd.visit) begin
         eidx_in = '0;
      end else if (cmd.edge_rd) begin
         eidx_in = eidx_ff + TB'(1);
      end
   end

   // The read register's edge word addresses the node tables; the relax follows
   // in the next cycle. A write by the previous relax is forwarded to the compare.
   assign e1_dst  = edge_rd_ff[WB+NB-1:WB];
   assign rd_addr = (cmd.scan_step || cmd.emit_load) ? sidx : e1_dst;
   assign {e_src, e_dst, e_w} = edge_d_ff;
   assign sum  = {1'b0, bdist_ff} + (CB+1)'(e_w);
   assign cand = sum[CB] ? spd_pkg::COST_MAX : sum[CB-1:0];
   assign dist_cur = (fw_vld_ff && fw_addr_ff == e_dst) ? fw_val_ff : dist_rd_ff;
   assign relax_hit = cmd.edge_relax && e_src == best_ff && KB'(e_dst) < n_eff &&
                      (!reach_ff[e_dst] || cand < dist_cur);

   always_ff @(posedge clock) begin
      if (relax_hit) begin
         dist_ff[e_dst] <= cand;
         pred_ff[e_dst] <= best_ff;
      end else if (cmd.init) begin
         dist_ff[req_word.start_node] <= '0;
      end
      dist_rd_ff <= dist_ff[rd_addr];
      pred_rd_ff <= pred_ff[rd_addr];
      edge_d_ff  <= edge_rd_ff;
      fw_addr_ff <= e_dst;
      fw_val_ff  <= cand;
      sidx_d_ff  <= sidx;
      if (cmd.init) begin
         start_ff <= req_word.start_node;
      end
      if (cmd.emit_load) begin
         rsp_ff.node_index      <= sidx;
         rsp_ff.has_predecessor <= pv_ff[sidx];
         rsp_ff.reached         <= reach_ff[sidx];
         rsp_ff.edges_dropped   <= ovf_ff;
         rsp_ff.last            <= (scan_ff + KB'(1)) == n_eff;
      end
      if (emit_d_ff) begin
         rsp_ff.path_cost   <= rsp_ff.reached ? dist_rd_ff : '0;
         rsp_ff.predecessor <= rsp_ff.has_predecessor ? pred_rd_ff : '0;
      end
      scan_ff  <= scan_in;
      best_ff  <= best_in;
      found_ff <= found_in;
      bdist_ff <= bdist_in;
      eidx_ff  <= eidx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         etot_ff   <= '0;
         ovf_ff    <= 1'b0;
         pv_ff     <= '0;
         reach_ff  <= '0;
         vis_ff    <= '0;
         step_d_ff <= 1'b0;
         emit_d_ff <= 1'b0;
         fw_vld_ff <= 1'b0;
      end else begin
         etot_ff   <= etot_in;
         ovf_ff    <= ovf_in;
         step_d_ff <= scan_issue;
         emit_d_ff <= cmd.emit_load;
         fw_vld_ff <= relax_hit;
         if (cmd.init) begin
            pv_ff    <= '0;
            vis_ff   <= '0;
            reach_ff <= '0;
            if (KB'(req_word.start_node) < n_eff) begin
               reach_ff[req_word.start_node] <= 1'b1;
            end
         end
         if (cmd.visit) begin
            vis_ff[best_ff] <= 1'b1;
         end
         if (relax_hit) begin
            reach_ff[e_dst] <= 1'b1;
            pv_ff[e_dst]    <= 1'b1;
         end
      end
   end

   assign sts.scan_done = scan_ff >= n_eff && !step_d_ff;
   assign sts.found     = found_ff;
   assign sts.edge_done = eidx_ff >= etot_ff;
   assign sts.emit_done = scan_ff >= n_eff;
   assign rsp_word      = rsp_ff;

   `ASSERT_CLK(a_etot_cap, clock, reset, etot_ff <= TB'(spd_pkg::MAX_EDGES), "edge total over capacity")
   `ASSERT_CLK(a_visit_found, clock, reset, cmd.visit |-> found_ff, "visit without a found node")
   `ASSERT_CLK(a_start_pred, clock, reset, $past(cmd.init) |-> !pv_ff[start_ff], "start has pred")
endmodule
`default_nettype wire

FILE: hw/rtl/spd_ctrl.sv
// Controller state machine of the shortest path block.
// Depends on spd_pkg; drives the datapath by commands and reads its status.
`default_nettype none
module spd_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [1:0]        req_command,
   output      logic              req_ready,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic              load_we,
   output      logic              clear_we,
   output      spd_pkg::cmd_type  cmd,
   input  wire spd_pkg::sts_type  sts
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_PICK  = 3'd2;
   localparam logic [2:0] ST_EDGE  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;
   localparam logic [2:0] ST_WAIT  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       relax_ff, relax_in;
   logic       relax2_ff, relax2_in;
   logic       acc;

   assign req_ready = state_ff == ST_IDLE;
   assign acc       = req_valid && req_ready;
   assign load_we   = acc && req_command == spd_pkg::CMD_LOAD;
   assign clear_we  = acc && req_command == spd_pkg::CMD_CLEAR;
   assign rsp_valid = state_ff == ST_OUT;

   // relax_ff marks an edge word in the read register, relax2_ff the relax stage.
   always_comb begin
      state_in  = state_ff;
      relax_in  = 1'b0;
      relax2_in = relax_ff;
      cmd       = '0;
      cmd.edge_relax = relax2_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc && req_command == spd_pkg::CMD_RUN) begin
               cmd.init = 1'b1;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            cmd.scan_clr = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               if (sts.found) begin
                  cmd.visit = 1'b1;
                  state_in = ST_EDGE;
               end else begin
                  cmd.scan_clr = 1'b1;
                  state_in = ST_EMIT;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_EDGE: begin
            if (sts.edge_done) begin
               if (!relax_ff && !relax2_ff) begin
                  state_in = ST_PICK;
               end
            end else begin
               cmd.edge_rd = 1'b1;
               relax_in = 1'b1;
            end
         end
         ST_EMIT: begin
            cmd.emit_load = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = sts.emit_done ? ST_IDLE : ST_EMIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         relax_ff  <= 1'b0;
         relax2_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         relax_ff  <= relax_in;
         relax2_ff <= relax2_in;
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/shortest_path_dijkstra.sv
// Top level of the single source shortest path block.
// Depends on spd_pkg, spd_ctrl and spd_dp.
//
// Usage: the req channel carries one word per command. A load word stores one
// edge; a full store drops it and sets the sticky dropped flag. A clear word
// empties the store and clears the flag. A run word starts a search from
// start_node and then returns one rsp word per node in use, in node order, with
// last set on the final one. An unknown command is ignored.
// Flow: a run repeats a visit per reached node: each visit scans all nodes for
// the minimum at one node a cycle, then sweeps the edge memory at one edge a
// cycle and drains the read and relax stages. A final scan that finds no node
// ends the search. Results then come one at a time, the next word loaded only
// after the receiver takes the last one. A stalled receiver holds the current
// rsp word and the block waits; no new word is taken during a run. node_count
// is written through csr_; the user must write it only while idle, and the block
// itself does not enforce this. Reset empties the edge store, clears the flag
// and sets node_count to 64.
`default_nettype none
module shortest_path_dijkstra (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire spd_pkg::req_type  req_word,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      spd_pkg::rsp_type  rsp_word,
   input  wire logic              csr_write,
   input  wire logic [6:0]        csr_wdata
);
   logic [6:0]       ncount_ff;
   logic             load_we, clear_we;
   spd_pkg::cmd_type cmd;
   spd_pkg::sts_type sts;

   // Node count register; the user must write it only while idle (not enforced).
   always_ff @(posedge clock) begin
      if (reset) begin
         ncount_ff <= 7'(spd_pkg::MAX_NODES);
      end else if (csr_write) begin
         ncount_ff <= csr_wdata;
      end
   end

   spd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_word.command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .load_we     (load_we),
      .clear_we    (clear_we),
      .cmd         (cmd),
      .sts         (sts)
   );

   spd_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .node_count (ncount_ff),
      .load_we    (load_we),
      .clear_we   (clear_we),
      .req_word   (req_word),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_word   (rsp_word)
   );
endmodule
`default_nettype wire
